### hw/rtl/srd_pkg.sv
// Shared types and constants of the sprite run-length row decoder.
package srd_pkg;

  localparam int MAX_DIM_DEFAULT = 256;

  localparam int COL_W = 9;
  localparam int ROW_W = 9;
  localparam int RUN_W = 7;
  localparam int CNT_W = 17;
  localparam int ADDR_W = 4;

  localparam logic [7:0] LINE_END = 8'h80;
  localparam logic [7:0] LOW_MASK = 8'h7F;
  localparam logic [COL_W-1:0] COL_MAX = '1;
  localparam logic [ROW_W-1:0] ROW_TOP = '1;

  localparam logic [COL_W-1:0] WIDTH_RESET = 9'd256;
  localparam logic [ROW_W-1:0] HEIGHT_RESET = 9'd256;
  localparam logic [CNT_W-1:0] LENGTH_RESET = 17'd1;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_COMP_LENGTH  = 2'd2,
    REG_NONE         = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [COL_W-1:0] frame_width;
    logic [ROW_W-1:0] frame_height;
    logic [CNT_W-1:0] compressed_length;
  } srd_cfg_t;

  typedef struct packed {
    logic       write_valid;
    logic [7:0] pixel_x;
    logic [7:0] pixel_row;
    logic [7:0] color;
    logic       frame_done;
    logic       status;
  } srd_result_t;

endpackage

### hw/rtl/sprite_rle_row_decoder_unit.sv
// Top level of the sprite run-length row decoder: register port, decoder and output buffer.
//
// The block takes one compressed byte per input beat on byte_in (in_valid,
// in_stall) and returns at most one result beat per byte on the output channel
// (out_valid, out_stall). A result is produced for every literal color byte,
// whether written or suppressed as outside the frame, and for the last byte of
// a frame, which also carries frame_done. Other control bytes give no beat.
// Each result is registered in the output register, or first in the skid
// entry; a new byte can be taken in every cycle while in_stall is low, so the
// sustained rate is one byte per clock, set by the column, row and run count update.
// The output register is backed by one skid entry: a stalled receiver lets one
// more result be buffered, after which in_stall rises until the output drains.
// Frame width, height and compressed length are written through the APB port
// at byte addresses 0, 4 and 8; each write to them rearms the decoder for a new frame.
// Synchronous reset restores width 256, height 256 and length 1, rearms the
// decoder at the bottom row and empties the output buffer.
module sprite_rle_row_decoder_unit import srd_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        byte_in,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              write_valid,
  output logic [7:0]        pixel_x,
  output logic [7:0]        pixel_row,
  output logic [7:0]        color,
  output logic              frame_done,
  output logic              status
);

  srd_cfg_t         cfg;
  reg_index_t       reg_sel;
  logic             cfg_write;
  logic [ROW_W-1:0] rearm_height;
  logic             take;
  logic             have;
  srd_result_t      result;
  srd_result_t      out_data;
  srd_result_t      skid_data;
  logic             skid_valid;

  assign pready = 1'b1;
  assign reg_sel = reg_index_t'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite && (reg_sel != REG_NONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width <= WIDTH_RESET;
      cfg.frame_height <= HEIGHT_RESET;
      cfg.compressed_length <= LENGTH_RESET;
    end else if (cfg_write) begin
      case (reg_sel)
        REG_FRAME_WIDTH:  cfg.frame_width <= pwdata[COL_W-1:0];
        REG_FRAME_HEIGHT: cfg.frame_height <= pwdata[ROW_W-1:0];
        REG_COMP_LENGTH:  cfg.compressed_length <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (rst) begin
      rearm_height = HEIGHT_RESET;
    end else if (cfg_write && reg_sel == REG_FRAME_HEIGHT) begin
      rearm_height = pwdata[ROW_W-1:0];
    end else begin
      rearm_height = cfg.frame_height;
    end
  end

  always_comb begin
    case (reg_sel)
      REG_FRAME_WIDTH:  prdata = 32'(cfg.frame_width);
      REG_FRAME_HEIGHT: prdata = 32'(cfg.frame_height);
      REG_COMP_LENGTH:  prdata = 32'(cfg.compressed_length);
      default:          prdata = '0;
    endcase
  end

  assign in_stall = skid_valid;
  assign take = in_valid && !skid_valid;

  srd_core #(
    .MAX_DIM (MAX_DIM)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .rearm        (cfg_write),
    .rearm_height (rearm_height),
    .take         (take),
    .byte_in      (byte_in),
    .have         (have),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && out_stall) begin
      if (take && have) begin
        skid_valid <= 1'b1;
        skid_data <= result;
      end
    end else if (skid_valid) begin
      out_valid <= 1'b1;
      out_data <= skid_data;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= take && have;
      out_data <= result;
    end
  end

  assign write_valid = out_data.write_valid;
  assign pixel_x = out_data.pixel_x;
  assign pixel_row = out_data.pixel_row;
  assign color = out_data.color;
  assign frame_done = out_data.frame_done;
  assign status = out_data.status;

endmodule

### hw/rtl/srd_core.sv
// Decode state and per-byte next-state and result logic of the row decoder.
module srd_core import srd_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  srd_cfg_t         cfg,
  input  logic             rearm,
  input  logic [ROW_W-1:0] rearm_height,
  input  logic             take,
  input  logic [7:0]       byte_in,
  output logic             have,
  output srd_result_t      result
);

  localparam logic [COL_W-1:0] DIM_LIMIT = COL_W'(MAX_DIM);

  logic [COL_W-1:0] column, column_next;
  logic [ROW_W-1:0] row, row_next;
  logic [RUN_W-1:0] literal_left, literal_left_next;
  logic [CNT_W-1:0] bytes_taken, bytes_taken_next;

  logic [COL_W:0]   col_sum;
  logic [RUN_W-1:0] skip;
  logic             in_frame;
  logic             done;

  always_comb begin
    skip = RUN_W'(byte_in & LOW_MASK);
    in_frame = (column < cfg.frame_width) && (column < DIM_LIMIT) &&
               (row < cfg.frame_height) && (row < DIM_LIMIT);
    col_sum = {1'b0, column} + (COL_W + 1)'(1);
    column_next = column;
    row_next = row;
    literal_left_next = literal_left;
    result = '0;
    have = 1'b0;
    if (literal_left != '0) begin
      have = 1'b1;
      if (in_frame) begin
        result.write_valid = 1'b1;
        result.pixel_x = column[7:0];
        result.pixel_row = row[7:0];
        result.color = byte_in;
      end else begin
        result.status = 1'b1;
      end
      column_next = col_sum[COL_W] ? COL_MAX : col_sum[COL_W-1:0];
      literal_left_next = literal_left - RUN_W'(1);
    end else if (byte_in == LINE_END) begin
      column_next = '0;
      row_next = (row == '0 || row == ROW_TOP) ? ROW_TOP : row - ROW_W'(1);
    end else if (byte_in[7]) begin
      col_sum = {1'b0, column} + (COL_W + 1)'(skip);
      column_next = col_sum[COL_W] ? COL_MAX : col_sum[COL_W-1:0];
    end else begin
      literal_left_next = skip;
    end
    bytes_taken_next = bytes_taken + CNT_W'(1);
    done = bytes_taken_next >= cfg.compressed_length;
    if (done) begin
      have = 1'b1;
      result.frame_done = 1'b1;
      column_next = '0;
      row_next = cfg.frame_height - ROW_W'(1);
      literal_left_next = '0;
      bytes_taken_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || rearm) begin
      column <= '0;
      row <= rearm_height - ROW_W'(1);
      literal_left <= '0;
      bytes_taken <= '0;
    end else if (take) begin
      column <= column_next;
      row <= row_next;
      literal_left <= literal_left_next;
      bytes_taken <= bytes_taken_next;
    end
  end

endmodule

### verif/tb_top.sv
// Self-checking testbench for the sprite run-length row decoder with a built-in decode predictor.
module tb_top import srd_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_DIM = MAX_DIM_DEFAULT;
  localparam int SETTLE_CYCLES = 4;
  localparam int CYCLE_LIMIT = 400000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [7:0]        byte_in = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              write_valid;
  logic [7:0]        pixel_x;
  logic [7:0]        pixel_row;
  logic [7:0]        color;
  logic              frame_done;
  logic              status;

  logic [COL_W-1:0] cfg_width = WIDTH_RESET;
  logic [ROW_W-1:0] cfg_height = HEIGHT_RESET;
  logic [CNT_W-1:0] cfg_length = LENGTH_RESET;
  logic [COL_W-1:0] col_q;
  logic [ROW_W-1:0] row_q;
  logic [RUN_W-1:0] run_left;
  logic [CNT_W-1:0] taken;

  srd_result_t predicted_pixels[$];
  srd_result_t head;
  int mismatch_count = 0;
  int cycle_count = 0;
  int in_gap_pct = 0;
  int out_stall_pct = 0;

  sprite_rle_row_decoder_unit #(
    .MAX_DIM(MAX_DIM)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .byte_in(byte_in),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .write_valid(write_valid),
    .pixel_x(pixel_x),
    .pixel_row(pixel_row),
    .color(color),
    .frame_done(frame_done),
    .status(status)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[sprite_rle_row_decoder_unit] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < out_stall_pct);
  end

  function automatic void rearm_model();
    col_q = '0;
    row_q = cfg_height - 1'b1;
    run_left = '0;
    taken = '0;
  endfunction

  function automatic logic [COL_W-1:0] col_advance(input logic [COL_W-1:0] c,
                                                   input logic [6:0] n);
    logic [COL_W:0] s;
    s = c + n;
    return (s > COL_MAX) ? COL_MAX : s[COL_W-1:0];
  endfunction

  function automatic logic decode_byte(input logic [7:0] b, output srd_result_t r);
    logic have;
    have = 1'b0;
    r = '0;
    if (run_left != 0) begin
      have = 1'b1;
      if (col_q < cfg_width && col_q < MAX_DIM && row_q < cfg_height && row_q < MAX_DIM) begin
        r.write_valid = 1'b1;
        r.pixel_x = col_q[7:0];
        r.pixel_row = row_q[7:0];
        r.color = b;
      end else begin
        r.status = 1'b1;
      end
      col_q = col_advance(col_q, 7'd1);
      run_left = run_left - 1'b1;
    end else if (b == LINE_END) begin
      col_q = '0;
      row_q = (row_q == 0 || row_q == ROW_TOP) ? ROW_TOP : row_q - 1'b1;
    end else if (b[7]) begin
      col_q = col_advance(col_q, b[6:0] & LOW_MASK[6:0]);
    end else begin
      run_left = b[6:0];
    end
    taken = taken + 1'b1;
    if (taken >= cfg_length) begin
      r.frame_done = 1'b1;
      have = 1'b1;
      rearm_model();
    end
    return have;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (predicted_pixels.size() == 0) begin
        $display({"%0t: unexpected result, expected none, ",
                  "actual wv=%0h x=%0h row=%0h c=%0h d=%0h s=%0h"},
                 $time, write_valid, pixel_x, pixel_row, color, frame_done, status);
        mismatch_count++;
      end else begin
        head = predicted_pixels.pop_front();
        check_field("write_valid", 8'(head.write_valid), 8'(write_valid));
        check_field("pixel_x", head.pixel_x, pixel_x);
        check_field("pixel_row", head.pixel_row, pixel_row);
        check_field("color", head.color, color);
        check_field("frame_done", 8'(head.frame_done), 8'(frame_done));
        check_field("status", 8'(head.status), 8'(status));
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    srd_result_t r;
    while ($urandom_range(99) < in_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    byte_in <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (decode_byte(b, r)) predicted_pixels.push_back(r);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (predicted_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input reg_index_t idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      REG_FRAME_WIDTH: cfg_width = value[COL_W-1:0];
      REG_FRAME_HEIGHT: cfg_height = value[ROW_W-1:0];
      REG_COMP_LENGTH: cfg_length = value[CNT_W-1:0];
      default: ;
    endcase
    if (idx != REG_NONE) rearm_model();
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic reg_check(input reg_index_t idx, input logic [31:0] want);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== want) begin
      $display("%0t: register %s read mismatch, expected %0h, actual %0h",
               $time, idx.name(), want, prdata);
      mismatch_count++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_dim();
    case ($urandom_range(11))
      0: return 32'd0;
      1: return 32'd256;
      2: return 32'd257 + $urandom_range(0, 254);
      3: return 32'd1;
      default: return $urandom_range(2, 12);
    endcase
  endfunction

  task automatic test_line_runs();
    logic [7:0] walk[$] = '{8'h02, 8'h00, 8'hFF, 8'h83, 8'h01, 8'hAA, LINE_END,
                            8'h01, 8'h55, LINE_END, 8'h01, 8'h11, LINE_END,
                            8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h7F};
    logic [7:0] tiny[$] = '{8'h01, 8'h81};
    logic [7:0] empty_frame[$] = '{8'h01, 8'h42, LINE_END};
    wait_drained();
    reg_write(REG_FRAME_WIDTH, 32'd4);
    reg_write(REG_FRAME_HEIGHT, 32'd2);
    reg_write(REG_COMP_LENGTH, 32'd20);
    foreach (walk[i]) send_byte(walk[i]);
    wait_drained();
    reg_write(REG_COMP_LENGTH, 32'd0);
    foreach (tiny[i]) send_byte(tiny[i]);
    wait_drained();
    reg_write(REG_FRAME_WIDTH, 32'd0);
    reg_write(REG_COMP_LENGTH, 32'd3);
    foreach (empty_frame[i]) send_byte(empty_frame[i]);
    wait_drained();
  endtask

  task automatic test_register_port();
    logic [7:0] far_row[$] = '{8'h01, 8'h33};
    logic [7:0] wide_row[$] = '{8'hFF, 8'hFF, 8'h82, 8'h01, 8'h10, LINE_END, 8'h01, 8'h20};
    wait_drained();
    reg_write(REG_FRAME_WIDTH, 32'hFFFF_FFFF);
    reg_write(REG_FRAME_HEIGHT, 32'h0000_0000);
    reg_write(REG_COMP_LENGTH, 32'hFFFF_FFFF);
    reg_check(REG_FRAME_WIDTH, 32'h0000_01FF);
    reg_check(REG_FRAME_HEIGHT, 32'h0000_0000);
    reg_check(REG_COMP_LENGTH, 32'h0001_FFFF);
    foreach (far_row[i]) send_byte(far_row[i]);
    wait_drained();
    // A write past the register list must leave the decoder mid-run.
    send_byte(8'h02);
    wait_drained();
    reg_write(REG_NONE, 32'hFFFF_FFFF);
    send_byte(8'h44);
    send_byte(8'h45);
    wait_drained();
    reg_write(REG_FRAME_HEIGHT, 32'd256);
    reg_check(REG_FRAME_HEIGHT, 32'd256);
    foreach (wide_row[i]) send_byte(wide_row[i]);
    wait_drained();
  endtask

  task automatic test_random_frames(input int gap_pct, input int stall_pct, input int n_bytes);
    int sent;
    int budget;
    int dice;
    logic [31:0] len;
    logic [7:0] b;
    in_gap_pct = gap_pct;
    out_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_bytes) begin
      wait_drained();
      reg_write(REG_FRAME_WIDTH, pick_dim());
      reg_write(REG_FRAME_HEIGHT, pick_dim());
      dice = $urandom_range(19);
      if (dice == 0) len = 32'd0;
      else if (dice == 1) len = 32'h0001_FFFF;
      else len = $urandom_range(1, 60);
      reg_write(REG_COMP_LENGTH, len);
      budget = (len > 200) ? 80 : len * $urandom_range(1, 4);
      if (budget > 200) budget = 200;
      if (budget == 0) budget = 3;
      repeat (budget) begin
        if (run_left != 0) begin
          b = 8'($urandom);
        end else begin
          dice = $urandom_range(99);
          if (dice < 6) b = 8'($urandom);
          else if (dice < 26) b = LINE_END;
          else if (dice < 36) b = {1'b1, 7'($urandom_range(1, 127))};
          else if (dice < 50) b = {1'b1, 7'($urandom_range(1, 6))};
          else b = 8'($urandom_range(0, 8));
        end
        send_byte(b);
        sent++;
      end
    end
    wait_drained();
  endtask

  initial begin
    rearm_model();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_line_runs();
    test_register_port();
    test_random_frames(0, 0, 325);
    test_random_frames(60, 0, 325);
    test_random_frames(0, 60, 325);
    test_random_frames(20, 20, 325);
    wait_drained();
    if (mismatch_count == 0 && predicted_pixels.size() == 0) begin
      $display("[sprite_rle_row_decoder_unit] OK");
    end else begin
      $display("[sprite_rle_row_decoder_unit] ERROR");
    end
    $finish;
  end

endmodule
